### design/pixel_to_ascii_art_stream_defines.svh
// Assertion macros shared by the pixel_to_ascii_art_stream design files.
`ifndef PIXEL_TO_ASCII_ART_STREAM_DEFINES_SVH
`define PIXEL_TO_ASCII_ART_STREAM_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define P2A_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define P2A_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define P2A_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### design/p2a_pkg.sv
// Package with the constants, types and helper functions of the ASCII art stream.
`timescale 1ns / 1ps

package p2a_pkg;

    // Ramp table and row geometry.
    localparam int unsigned RAMP_DEPTH     = 128;
    localparam int unsigned RAMP_AW        = $clog2(RAMP_DEPTH);
    localparam int unsigned MAX_LINE_WIDTH = 4096;
    localparam int unsigned COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int unsigned WEFF_W         = $clog2(MAX_LINE_WIDTH + 1);

    // Field widths fixed by the interface.
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned LW_W    = 13;
    localparam int unsigned CFG_DW  = 13;
    localparam int unsigned CFG_IW  = 2;

    // Depth of the job queue between front and back.
    localparam int unsigned QDEPTH  = 4;

    // Luminance arithmetic: weights over 2^16, then a divide by 255 via reciprocal.
    localparam int unsigned LUM_W    = 24;
    localparam int unsigned PROD_W   = LUM_W + RAMP_AW;
    localparam int unsigned X_W      = PROD_W - 16;
    localparam int unsigned RCP_W    = X_W + 16;
    localparam int unsigned RCP_SH   = 23;
    localparam int unsigned QIDX_W   = RAMP_AW + 1;
    localparam logic [15:0] RECIP_255 = 16'd32897;
    localparam logic [15:0] LUM_WEIGHT [3] = '{16'd13933, 16'd46871, 16'd4732};

    // Item operation codes.
    localparam logic OP_PIXEL       = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        CFG_RAMP_LENGTH = 2'd0,
        CFG_INVERT_RAMP = 2'd1,
        CFG_COLOR_MODE  = 2'd2,
        CFG_LINE_WIDTH  = 2'd3
    } cfg_idx_t;

    // Text bytes.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_M       = 8'h6D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam int unsigned PREFIX_LEN  = 7;
    localparam int unsigned RESET_LEN   = 4;
    localparam logic [7:0] ESC_PREFIX [PREFIX_LEN] =
        '{8'h1B, 8'h5B, 8'h33, 8'h38, 8'h3B, 8'h32, 8'h3B};
    localparam logic [7:0] ESC_RESET [RESET_LEN] = '{8'h1B, 8'h5B, 8'h30, 8'h6D};

    // Default ramp, dark to light.
    localparam int unsigned DEFAULT_LEN = 70;
    localparam int unsigned DEF_AW      = $clog2(DEFAULT_LEN);
    localparam logic [7:0] DEFAULT_RAMP [DEFAULT_LEN] = '{
        8'h24, 8'h40, 8'h42, 8'h25, 8'h38, 8'h26, 8'h57, 8'h4D, 8'h23, 8'h2A,
        8'h6F, 8'h61, 8'h68, 8'h6B, 8'h62, 8'h64, 8'h70, 8'h71, 8'h77, 8'h6D,
        8'h5A, 8'h4F, 8'h30, 8'h51, 8'h4C, 8'h43, 8'h4A, 8'h55, 8'h59, 8'h58,
        8'h7A, 8'h63, 8'h76, 8'h75, 8'h6E, 8'h78, 8'h72, 8'h6A, 8'h66, 8'h74,
        8'h2F, 8'h5C, 8'h7C, 8'h28, 8'h29, 8'h31, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
        8'h3F, 8'h2D, 8'h5F, 8'h2B, 8'h7E, 8'h3C, 8'h3E, 8'h69, 8'h21, 8'h6C,
        8'h49, 8'h3B, 8'h3A, 8'h2C, 8'h22, 8'h5E, 8'h60, 8'h27, 8'h2E, 8'h20
    };

    // Configuration seen by front and back.
    typedef struct packed {
        logic [LEN_W-1:0] ramp_length;
        logic             invert_ramp;
        logic             color_mode;
        logic [LW_W-1:0]  line_width;
    } cfg_t;

    // Decimal digits of one color component.
    typedef struct packed {
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } dec_t;

    // One classified job handed from front to back.
    typedef struct packed {
        logic               op;
        logic [RAMP_AW-1:0] addr;
        logic [7:0]         wchar;
        dec_t [2:0]         dig;
        logic               row_end;
    } job_t;

    // Reset content of a ramp entry that has not been written yet.
    function automatic logic [7:0] default_char(input logic [RAMP_AW-1:0] a);
        logic [7:0] c;
        c = 8'h00;
        if (int'(a) < DEFAULT_LEN)
        begin
            c = DEFAULT_RAMP[DEF_AW'(a)];
        end
        return c;
    endfunction

    // Position of the first printed digit: no leading zeros.
    function automatic logic [1:0] first_digit(input dec_t d);
        logic [1:0] p;
        if (d.hund != 2'd0)
        begin
            p = 2'd0;
        end
        else if (d.tens != 4'd0)
        begin
            p = 2'd1;
        end
        else
        begin
            p = 2'd2;
        end
        return p;
    endfunction

    // ASCII byte of the digit at a position.
    function automatic logic [7:0] digit_char(input dec_t d, input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = CHAR_ZERO + {6'd0, d.hund};
            2'd1:    c = CHAR_ZERO + {4'd0, d.tens};
            default: c = CHAR_ZERO + {4'd0, d.ones};
        endcase
        return c;
    endfunction

endpackage

### design/p2a_if.sv
// Stream interfaces for the pixel input channel and the text output channel.
`timescale 1ns / 1ps

interface p2a_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] entry_index;
    logic [7:0] entry_char;

    modport source (output valid, op, red, green, blue, entry_index, entry_char,
                    input ready);
    modport sink (input valid, op, red, green, blue, entry_index, entry_char,
                  output ready);
endinterface

interface p2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

### design/pixel_to_ascii_art_stream.sv
// Top level of the pixel to ASCII art text stream.
`timescale 1ns / 1ps
// Usage:
// pixels carries items: op 0 is an RGB pixel in raster order, op 1 writes one
// ramp table entry (entry_index, entry_char). text carries the output bytes;
// last_of_run marks the final byte caused by a pixel. Both are valid/ready.
// cfg_we, cfg_index and cfg_wdata write ramp_length, invert_ramp, color_mode
// and line_width; write them only while no transaction is in flight.
// Path: a pixel passes the front sequencer steps, the job queue, the back
// end's job fetch and its output register before its first byte is on text.
// Pacing: the front takes no new item until it has pushed the last one; a
// table write skips straight to the push step. The back end sends one byte
// per cycle while text is not stalled, after it fetches each job from the queue.
// A four-entry job queue lets the two sides run apart.
// Reset: the ramp table reads as the 70-character default ramp, the column
// count is zero and the registers take their defaults; no clearing pass.
// A stalled receiver holds the output byte; the queue then fills and pixels
// drops ready until bytes drain.

module pixel_to_ascii_art_stream
    import p2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    p2a_in_if.sink            pixels,
    p2a_out_if.source         text,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t push_job;
    job_t pop_job;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_length <= LEN_W'(70);
            cfg_reg.invert_ramp <= 1'b0;
            cfg_reg.color_mode  <= 1'b0;
            cfg_reg.line_width  <= LW_W'(80);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RAMP_LENGTH: cfg_reg.ramp_length <= cfg_wdata[LEN_W-1:0];
                CFG_INVERT_RAMP: cfg_reg.invert_ramp <= cfg_wdata[0];
                CFG_COLOR_MODE:  cfg_reg.color_mode  <= cfg_wdata[0];
                CFG_LINE_WIDTH:  cfg_reg.line_width  <= cfg_wdata[LW_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    p2a_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    p2a_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    p2a_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .text    (text)
    );

endmodule

### design/p2a_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module p2a_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/p2a_front.sv
// Front end: accepts items, computes the ramp index and decimal digits, tracks columns.
`timescale 1ns / 1ps

module p2a_front
    import p2a_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    p2a_in_if.sink pixels,
    input  cfg_t   cfg,
    input  logic   q_full,
    output logic   q_push,
    output job_t   q_job
);

    // Sequencer steps.
    typedef enum logic [6:0] {
        STEP_MUL   = 7'b0000001,
        STEP_SUM   = 7'b0000010,
        STEP_SCALE = 7'b0000100,
        STEP_RECIP = 7'b0001000,
        STEP_FIX   = 7'b0010000,
        STEP_IDX   = 7'b0100000,
        STEP_PUSH  = 7'b1000000
    } fstep_t;

    logic                busy_reg;
    fstep_t              step_reg;
    fstep_t              step_next;
    logic [COL_W-1:0]    col_reg;

    logic                op_reg;
    logic                keep_reg;
    logic [RAMP_AW-1:0]  addr_reg;
    logic [7:0]          char_reg;
    logic [7:0]          rgb_reg   [3];
    logic [LUM_W-1:0]    prod_reg  [3];
    logic [1:0]          hund_reg  [3];
    logic [6:0]          rem_reg   [3];
    logic [3:0]          tens_reg  [3];
    logic [3:0]          ones_reg  [3];
    logic [LUM_W-1:0]    lum_reg;
    logic [PROD_W-1:0]   scaled_reg;
    logic [QIDX_W-1:0]   q0_reg;
    logic [QIDX_W-1:0]   q_reg;
    logic [RAMP_AW-1:0]  idx_reg;

    logic                accept;
    logic [RAMP_AW-1:0]  lenm1;
    logic [WEFF_W-1:0]   weff;
    logic                row_end;
    logic [X_W-1:0]      x_val;
    logic [RCP_W-1:0]    rcp_prod;
    logic [X_W-1:0]      rem255;
    logic [QIDX_W-1:0]   q_clamped;
    logic [13:0]         hund_prod [3];
    logic [7:0]          rem_full  [3];
    logic [14:0]         tens_prod [3];
    logic [6:0]          ones_full [3];

    assign accept       = pixels.valid && !busy_reg;
    assign pixels.ready = !busy_reg;

    // Effective ramp length minus one and effective row width.
    always_comb
    begin
        if (cfg.ramp_length == '0)
        begin
            lenm1 = '0;
        end
        else if (int'(cfg.ramp_length) > RAMP_DEPTH)
        begin
            lenm1 = RAMP_AW'(RAMP_DEPTH - 1);
        end
        else
        begin
            lenm1 = RAMP_AW'(cfg.ramp_length - LEN_W'(1));
        end

        if (cfg.line_width == '0)
        begin
            weff = WEFF_W'(1);
        end
        else if (int'(cfg.line_width) > MAX_LINE_WIDTH)
        begin
            weff = WEFF_W'(MAX_LINE_WIDTH);
        end
        else
        begin
            weff = WEFF_W'(cfg.line_width);
        end
    end

    // Reciprocal divide by 255 with a one-step correction, and the final clamp.
    always_comb
    begin
        x_val     = scaled_reg[PROD_W-1:16];
        rcp_prod  = RCP_W'(x_val) * RCP_W'(RECIP_255);
        rem255    = x_val - X_W'(q0_reg) * X_W'(255);
        q_clamped = (q_reg > QIDX_W'(lenm1)) ? QIDX_W'(lenm1) : q_reg;
    end

    // Per-component digit arithmetic.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            hund_prod[c] = 14'(rgb_reg[c]) * 14'd41;
            rem_full[c]  = rgb_reg[c] - 8'(hund_reg[c]) * 8'd100;
            tens_prod[c] = 15'(rem_reg[c]) * 15'd205;
            ones_full[c] = rem_reg[c] - 7'(tens_reg[c]) * 7'd10;
        end
    end

    // Datapath registers, one step per cycle; the push step holds while the queue is full.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= pixels.op;
            keep_reg   <= (int'(pixels.entry_index) < RAMP_DEPTH);
            addr_reg   <= RAMP_AW'(pixels.entry_index);
            char_reg   <= pixels.entry_char;
            rgb_reg[0] <= pixels.red;
            rgb_reg[1] <= pixels.green;
            rgb_reg[2] <= pixels.blue;
        end
        if (busy_reg && step_reg == STEP_MUL)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= LUM_W'(rgb_reg[c]) * LUM_W'(LUM_WEIGHT[c]);
                hund_reg[c] <= hund_prod[c][13:12];
            end
        end
        if (busy_reg && step_reg == STEP_SUM)
        begin
            lum_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2];
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= rem_full[c][6:0];
            end
        end
        if (busy_reg && step_reg == STEP_SCALE)
        begin
            scaled_reg <= PROD_W'(lum_reg) * PROD_W'(lenm1);
            for (int c = 0; c < 3; c++)
            begin
                tens_reg[c] <= tens_prod[c][14:11];
            end
        end
        if (busy_reg && step_reg == STEP_RECIP)
        begin
            q0_reg <= rcp_prod[RCP_SH+QIDX_W-1:RCP_SH];
            for (int c = 0; c < 3; c++)
            begin
                ones_reg[c] <= ones_full[c][3:0];
            end
        end
        if (busy_reg && step_reg == STEP_FIX)
        begin
            q_reg <= (rem255 >= X_W'(255)) ? q0_reg + QIDX_W'(1) : q0_reg;
        end
        if (busy_reg && step_reg == STEP_IDX)
        begin
            idx_reg <= cfg.invert_ramp ? lenm1 - q_clamped[RAMP_AW-1:0]
                                       : q_clamped[RAMP_AW-1:0];
        end
    end

    // Row end is decided as the pixel leaves for the back end.
    assign row_end = (32'(col_reg) + 32'd1) >= 32'(weff);

    always_comb
    begin
        q_push        = busy_reg && (step_reg == STEP_PUSH) && !q_full &&
                        (op_reg == OP_PIXEL || keep_reg);
        q_job.op      = op_reg;
        q_job.addr    = (op_reg == OP_TABLE_WRITE) ? addr_reg : idx_reg;
        q_job.wchar   = char_reg;
        q_job.row_end = row_end;
        for (int c = 0; c < 3; c++)
        begin
            q_job.dig[c].hund = hund_reg[c];
            q_job.dig[c].tens = tens_reg[c];
            q_job.dig[c].ones = ones_reg[c];
        end
    end

    // Step order of the sequencer; the push step holds until the queue has room.
    always_comb
    begin
        case (step_reg)
            STEP_MUL:   step_next = STEP_SUM;
            STEP_SUM:   step_next = STEP_SCALE;
            STEP_SCALE: step_next = STEP_RECIP;
            STEP_RECIP: step_next = STEP_FIX;
            STEP_FIX:   step_next = STEP_IDX;
            STEP_IDX:   step_next = STEP_PUSH;
            default:    step_next = STEP_PUSH;
        endcase
    end

    // Sequencer and column counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_MUL;
            col_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= (pixels.op == OP_TABLE_WRITE) ? STEP_PUSH : STEP_MUL;
            end
            else if (busy_reg)
            begin
                if (step_reg != STEP_PUSH)
                begin
                    step_reg <= step_next;
                end
                else if (!q_full)
                begin
                    busy_reg <= 1'b0;
                    if (op_reg == OP_PIXEL)
                    begin
                        col_reg <= row_end ? '0 : col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

endmodule

### design/p2a_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`include "pixel_to_ascii_art_stream_defines.svh"

module p2a_queue
    import p2a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int unsigned QAW = $clog2(QDEPTH);
    localparam int unsigned QCW = $clog2(QDEPTH + 1);

    job_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCW'(1);
            end
        end
    end

    `P2A_ASSERT_SAME(a_no_push_when_full, clk, rst_n, push, !full || pop, "push into a full queue")
    `P2A_ASSERT_SAME(a_no_pop_when_empty, clk, rst_n, pop, !empty, "pop from an empty queue")

endmodule

### design/p2a_back.sv
// Back end: owns the ramp table and serializes the text bytes of each job.
`timescale 1ns / 1ps
`include "pixel_to_ascii_art_stream_defines.svh"

module p2a_back
    import p2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       q_pop,
    p2a_out_if.source  text
);

    typedef enum logic [6:0] {
        B_IDLE    = 7'b0000001,
        B_PREFIX  = 7'b0000010,
        B_DIGIT   = 7'b0000100,
        B_SEP     = 7'b0001000,
        B_CHAR    = 7'b0010000,
        B_RESET   = 7'b0100000,
        B_NEWLINE = 7'b1000000
    } bst_t;

    bst_t                  state_reg;
    bst_t                  state_next;
    logic [2:0]            sub_reg;
    logic [2:0]            sub_next;
    logic [1:0]            chan_reg;
    logic [1:0]            chan_next;
    job_t                  job_reg;
    logic                  hit_reg;
    logic [RAMP_DEPTH-1:0] written_reg;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg;

    logic                  adv;
    logic                  emit;
    logic [7:0]            emit_byte;
    logic                  emit_last;
    logic                  ram_we;
    logic                  ram_re;
    logic [7:0]            ram_rdata;
    logic [7:0]            ramp_char;

    // Ramp table storage.
    p2a_ram #(
        .WIDTH (8),
        .DEPTH (RAMP_DEPTH)
    ) u_ramp (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_job.addr),
        .wdata (q_job.wchar),
        .re    (ram_re),
        .raddr (q_job.addr),
        .rdata (ram_rdata)
    );

    // Entries never written read as the default ramp.
    assign ramp_char = hit_reg ? ram_rdata : default_char(job_reg.addr);

    // The output register takes a new byte when empty or being drained.
    assign adv = !out_valid_reg || text.ready;

    // Byte sequencer.
    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        chan_next  = chan_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        emit       = 1'b0;
        emit_byte  = 8'h00;
        emit_last  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_job.op == OP_TABLE_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        sub_next   = 3'd0;
                        chan_next  = 2'd0;
                        state_next = cfg.color_mode ? B_PREFIX : B_CHAR;
                    end
                end
            end
            B_PREFIX:
            begin
                emit      = 1'b1;
                emit_byte = ESC_PREFIX[sub_reg];
                if (adv)
                begin
                    if (sub_reg == 3'(PREFIX_LEN - 1))
                    begin
                        state_next = B_DIGIT;
                        chan_next  = 2'd0;
                        sub_next   = {1'b0, first_digit(job_reg.dig[0])};
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            B_DIGIT:
            begin
                emit      = 1'b1;
                emit_byte = digit_char(job_reg.dig[chan_reg], sub_reg[1:0]);
                if (adv)
                begin
                    if (sub_reg == 3'd2)
                    begin
                        state_next = B_SEP;
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            B_SEP:
            begin
                emit      = 1'b1;
                emit_byte = (chan_reg == 2'd2) ? CHAR_M : CHAR_SEMI;
                if (adv)
                begin
                    if (chan_reg == 2'd2)
                    begin
                        state_next = B_CHAR;
                    end
                    else
                    begin
                        state_next = B_DIGIT;
                        chan_next  = chan_reg + 2'd1;
                        sub_next   = {1'b0, first_digit(job_reg.dig[chan_reg + 2'd1])};
                    end
                end
            end
            B_CHAR:
            begin
                emit      = 1'b1;
                emit_byte = ramp_char;
                emit_last = !job_reg.row_end;
                if (adv)
                begin
                    sub_next = 3'd0;
                    if (!job_reg.row_end)
                    begin
                        state_next = B_IDLE;
                    end
                    else if (cfg.color_mode)
                    begin
                        state_next = B_RESET;
                    end
                    else
                    begin
                        state_next = B_NEWLINE;
                    end
                end
            end
            B_RESET:
            begin
                emit      = 1'b1;
                emit_byte = ESC_RESET[sub_reg[1:0]];
                if (adv)
                begin
                    if (sub_reg == 3'(RESET_LEN - 1))
                    begin
                        state_next = B_NEWLINE;
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            B_NEWLINE:
            begin
                emit      = 1'b1;
                emit_byte = CHAR_NEWLINE;
                emit_last = 1'b1;
                if (adv)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Job capture and output payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
            hit_reg <= written_reg[q_job.addr];
        end
        if (adv && emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    // Control state, written-entry flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sub_reg       <= '0;
            chan_reg      <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            chan_reg  <= chan_next;
            if (ram_we)
            begin
                written_reg[q_job.addr] <= 1'b1;
            end
            if (adv)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    assign text.valid       = out_valid_reg;
    assign text.out_byte    = out_byte_reg;
    assign text.last_of_run = out_last_reg;

    `P2A_ASSERT_NEXT(a_char_ends_run, clk, rst_n, state_reg == B_CHAR && adv && !job_reg.row_end, state_reg == B_IDLE && text.valid && text.last_of_run, "character without row end must close the run")
    `P2A_ASSERT_SAME(a_chan_in_range, clk, rst_n, state_reg == B_DIGIT || state_reg == B_SEP, chan_reg != 2'd3, "color channel out of range")

endmodule
